// File: design/prf_pkg.sv
package prf_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] HDR_SHORT = 8'd7;
  localparam logic [7:0] HDR_LONG  = 8'd11;
  localparam logic [7:0] TAG_BYTES = 8'd16;
  localparam logic [8:0] AUTH_HDR  = {1'b0, HDR_LONG} + {1'b0, TAG_BYTES};

  localparam logic [7:0] RULE0_MAX_RST = 8'd248;
  localparam logic [7:0] RULE1_MAX_RST = 8'd244;
  localparam logic [7:0] RULE2_MAX_RST = 8'd228;

  localparam logic [1:0] CFG_RULE0_MAX = 2'd0;
  localparam logic [1:0] CFG_RULE1_MAX = 2'd1;
  localparam logic [1:0] CFG_RULE2_MAX = 2'd2;

  typedef enum logic [1:0] {
    OP_CTR  = 2'd0,
    OP_SESS = 2'd1,
    OP_AUTH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LEN    = 2'd1,
    ST_REPLAY = 2'd2,
    ST_AUTH   = 2'd3
  } status_t;

  // One classified header waiting for its table check
  typedef struct packed {
    op_t         rule;
    logic [7:0]  node;
    logic [31:0] sess;
    logic [31:0] ctr;
    logic [7:0]  plen;
    status_t     pre;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: design/prf_front.sv
module prf_front #(
  parameter int NODE_COUNT = prf_pkg::NODE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [7:0]       in_node_id,
  input  logic [31:0]      in_session_id,
  input  logic [31:0]      in_msg_counter,
  input  logic [7:0]       in_payload_len,
  input  logic [7:0]       in_frame_len,
  input  logic             in_tag_ok,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  prf_pkg::q_stat_t q_stat,
  output logic             q_push,
  output prf_pkg::entry_t  q_entry
);

  logic [7:0] rule0_max_r;
  logic [7:0] rule1_max_r;
  logic [7:0] rule2_max_r;

  logic [7:0]       sum_short;
  logic [7:0]       sum_long;
  logic [8:0]       sum_auth;
  logic             node_ok;
  prf_pkg::op_t     op;
  prf_pkg::status_t pre;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule0_max_r <= prf_pkg::RULE0_MAX_RST;
      rule1_max_r <= prf_pkg::RULE1_MAX_RST;
      rule2_max_r <= prf_pkg::RULE2_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        prf_pkg::CFG_RULE0_MAX: rule0_max_r <= cfg_data;
        prf_pkg::CFG_RULE1_MAX: rule1_max_r <= cfg_data;
        prf_pkg::CFG_RULE2_MAX: rule2_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign op        = prf_pkg::op_t'(in_opcode);
  assign sum_short = in_payload_len + prf_pkg::HDR_SHORT;
  assign sum_long  = in_payload_len + prf_pkg::HDR_LONG;
  assign sum_auth  = {1'b0, in_payload_len} + prf_pkg::AUTH_HDR;
  assign node_ok   = {1'b0, in_node_id} < 9'(NODE_COUNT);

  // Length, opcode and node checks; authentication ranks after length
  always_comb begin
    pre = prf_pkg::ST_OK;
    unique case (op)
      prf_pkg::OP_CTR: begin
        if (sum_short != in_frame_len || in_payload_len > rule0_max_r) begin
          pre = prf_pkg::ST_LEN;
        end
      end
      prf_pkg::OP_SESS: begin
        if (sum_long != in_frame_len || in_payload_len > rule1_max_r) begin
          pre = prf_pkg::ST_LEN;
        end
      end
      prf_pkg::OP_AUTH: begin
        if (sum_auth != {1'b0, in_frame_len} || in_payload_len > rule2_max_r) begin
          pre = prf_pkg::ST_LEN;
        end else if (!in_tag_ok) begin
          pre = prf_pkg::ST_AUTH;
        end
      end
      default: pre = prf_pkg::ST_LEN;
    endcase
    if (!node_ok) begin
      pre = prf_pkg::ST_LEN;
    end
  end

  assign in_stall     = q_stat.full;
  assign q_push       = in_valid && !q_stat.full;
  assign q_entry.rule = op;
  assign q_entry.node = in_node_id;
  assign q_entry.sess = in_session_id;
  assign q_entry.ctr  = in_msg_counter;
  assign q_entry.plen = in_payload_len;
  assign q_entry.pre  = pre;

endmodule

// File: design/prf_queue.sv
module prf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prf_pkg::entry_t  push_entry,
  input  logic             pop,
  output prf_pkg::entry_t  head,
  output prf_pkg::q_stat_t stat
);

  localparam int PW = (prf_pkg::QUEUE_DEPTH > 1) ? $clog2(prf_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(prf_pkg::QUEUE_DEPTH + 1);

  prf_pkg::entry_t slot_r [prf_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_nxt;

  assign stat.full  = count_r == CW'(prf_pkg::QUEUE_DEPTH);
  assign stat.empty = count_r == '0;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(prf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(prf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: design/prf_back.sv
module prf_back #(
  parameter int NODE_COUNT = prf_pkg::NODE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  prf_pkg::entry_t  q_head,
  input  prf_pkg::q_stat_t q_stat,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_accept,
  output logic [1:0]       out_status,
  output logic [7:0]       out_accepted_len
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic {
    S_IDLE,
    S_JUDGE
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  prf_pkg::entry_t  entry_r;
  logic             out_valid_r;
  logic             out_accept_r;
  prf_pkg::status_t out_status_r;
  logic [7:0]       out_accepted_len_r;

  logic [31:0] ctr0_mem [NODE_COUNT];
  logic [63:0] sc1_mem  [NODE_COUNT];
  logic [63:0] sc2_mem  [NODE_COUNT];
  logic [2:0]  seen_mem [NODE_COUNT];
  logic [31:0] ctr0_rd_r;
  logic [63:0] sc1_rd_r;
  logic [63:0] sc2_rd_r;
  logic [2:0]  seen_rd_r;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [2:0]       seen;
  logic [2:0]       seen_set;
  logic             done;
  logic             we;
  prf_pkg::status_t judge_status;

  assign rd_addr  = q_head.node[AW-1:0];
  assign wr_addr  = entry_r.node[AW-1:0];
  assign seen     = seen_rd_r;
  assign seen_set = 3'b001 << entry_r.rule;

  assign q_pop = (state_r == S_IDLE) && !q_stat.empty && !clr_busy_r;
  assign done  = (state_r == S_JUDGE) && (!out_valid_r || !out_stall);
  assign we    = done && (judge_status == prf_pkg::ST_OK);

  // Replay decision against the node's last accepted session and counter
  always_comb begin
    judge_status = entry_r.pre;
    if (entry_r.pre == prf_pkg::ST_OK) begin
      unique case (entry_r.rule)
        prf_pkg::OP_CTR: begin
          if (seen[0] && entry_r.ctr <= ctr0_rd_r) begin
            judge_status = prf_pkg::ST_REPLAY;
          end
        end
        prf_pkg::OP_SESS: begin
          if (seen[1] && (entry_r.sess < sc1_rd_r[63:32] ||
              (entry_r.sess == sc1_rd_r[63:32] && entry_r.ctr <= sc1_rd_r[31:0]))) begin
            judge_status = prf_pkg::ST_REPLAY;
          end
        end
        prf_pkg::OP_AUTH: begin
          if (seen[2] && entry_r.sess == sc2_rd_r[63:32] &&
              entry_r.ctr <= sc2_rd_r[31:0]) begin
            judge_status = prf_pkg::ST_REPLAY;
          end
        end
        default: judge_status = prf_pkg::ST_LEN;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_pop) state_nxt = S_JUDGE;
      S_JUDGE: if (done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        entry_r <= q_head;
      end
      if (done) begin
        out_valid_r        <= 1'b1;
        out_accept_r       <= judge_status == prf_pkg::ST_OK;
        out_status_r       <= judge_status;
        out_accepted_len_r <= (judge_status == prf_pkg::ST_OK) ? entry_r.plen : 8'd0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk the seen table once after reset; hold the queue until it is clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(NODE_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      seen_rd_r <= seen_mem[rd_addr];
    end
    if (clr_busy_r) begin
      seen_mem[clr_addr_r] <= '0;
    end else if (we) begin
      seen_mem[wr_addr] <= seen | seen_set;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctr0_rd_r <= ctr0_mem[rd_addr];
    end
    if (we && entry_r.rule == prf_pkg::OP_CTR) begin
      ctr0_mem[wr_addr] <= entry_r.ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sc1_rd_r <= sc1_mem[rd_addr];
    end
    if (we && entry_r.rule == prf_pkg::OP_SESS) begin
      sc1_mem[wr_addr] <= {entry_r.sess, entry_r.ctr};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sc2_rd_r <= sc2_mem[rd_addr];
    end
    if (we && entry_r.rule == prf_pkg::OP_AUTH) begin
      sc2_mem[wr_addr] <= {entry_r.sess, entry_r.ctr};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accept       = out_accept_r;
  assign out_status       = out_status_r;
  assign out_accepted_len = out_accepted_len_r;

  a_accept_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_accept_r == (out_status_r == prf_pkg::ST_OK)))
    else $error("accept flag disagrees with status");

  a_rejected_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_accept_r) |-> (out_accepted_len_r == 8'd0))
    else $error("rejected transaction carries a length");

  a_seen_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> ((seen_mem[$past(wr_addr)] & $past(seen_set)) == $past(seen_set)))
    else $error("seen flag not set after accepted transaction");

  a_no_pop_while_judging: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_JUDGE) |-> !q_pop)
    else $error("queue popped while a table check is in flight");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !q_pop)
    else $error("queue popped while the seen table is being cleared");

endmodule

// File: design/per_node_replay_filter.sv
// Anti-replay filter for parsed frame headers. Each transaction on the in_
// channel is checked for length, opcode, node and tag validity, then against
// the sending node's last accepted session and counter for its rule; exactly
// one result leaves on the out_ channel per header, in order. The front end
// takes a header in the cycle it is offered unless its two-entry queue is
// full. For each header the back end first reads the node's table entry from
// the registered-read memories, then compares and writes back, and it takes
// no new header from its queue until it is through with the last one. A held
// result does not block the queue from filling. After reset the back end
// clears the seen flags of all NODE_COUNT nodes (256 by default) one node per
// cycle and takes no header from its queue until they are clear; up to two
// headers are accepted meanwhile. cfg_ready is always high; write the length
// limits only while no header is in flight.
module per_node_replay_filter #(
  parameter int NODE_COUNT = prf_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_node_id,
  input  logic [31:0] in_session_id,
  input  logic [31:0] in_msg_counter,
  input  logic [7:0]  in_payload_len,
  input  logic [7:0]  in_frame_len,
  input  logic        in_tag_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accept,
  output logic [1:0]  out_status,
  output logic [7:0]  out_accepted_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  prf_pkg::q_stat_t q_stat;
  prf_pkg::entry_t  q_entry;
  prf_pkg::entry_t  q_head;
  logic             q_push;
  logic             q_pop;

  prf_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_node_id    (in_node_id),
    .in_session_id (in_session_id),
    .in_msg_counter(in_msg_counter),
    .in_payload_len(in_payload_len),
    .in_frame_len  (in_frame_len),
    .in_tag_ok     (in_tag_ok),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  prf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  prf_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accept      (out_accept),
    .out_status      (out_status),
    .out_accepted_len(out_accepted_len)
  );

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 2000;

  // Codes outside the package enums, driven on purpose
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  node;
    logic [31:0] sess;
    logic [31:0] ctr;
    logic [7:0]  plen;
    logic [7:0]  flen;
    logic        tag;
  } header_t;

  typedef struct {
    logic             accept;
    prf_pkg::status_t status;
    logic [7:0]       len;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [7:0]  in_node_id = '0;
  logic [31:0] in_session_id = '0;
  logic [31:0] in_msg_counter = '0;
  logic [7:0]  in_payload_len = '0;
  logic [7:0]  in_frame_len = '0;
  logic        in_tag_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accept;
  logic [1:0]  out_status;
  logic [7:0]  out_accepted_len;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // Replay tables and length limits as the block should hold them
  logic        seen_rules [3][NODES] = '{default: 1'b0};
  logic [31:0] last_sess  [3][NODES];
  logic [31:0] last_ctr   [3][NODES];
  logic [7:0]  max_plen   [3] = '{prf_pkg::RULE0_MAX_RST, prf_pkg::RULE1_MAX_RST,
                                  prf_pkg::RULE2_MAX_RST};

  verdict_t verdict_q [$];
  int       mismatches = 0;
  int       run_left = 0;
  int       hold_req = 0;
  logic     quiet = 1'b0;

  per_node_replay_filter #(
    .NODE_COUNT(NODES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_node_id       (in_node_id),
    .in_session_id    (in_session_id),
    .in_msg_counter   (in_msg_counter),
    .in_payload_len   (in_payload_len),
    .in_frame_len     (in_frame_len),
    .in_tag_ok        (in_tag_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accept       (out_accept),
    .out_status       (out_status),
    .out_accepted_len (out_accepted_len),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic header_t frame_hdr(logic [1:0] op, logic [7:0] node, logic [31:0] sess,
                                        logic [31:0] ctr, logic [7:0] plen, logic [7:0] flen,
                                        logic tag);
    header_t h;
    h.opcode = op;
    h.node   = node;
    h.sess   = sess;
    h.ctr    = ctr;
    h.plen   = plen;
    h.flen   = flen;
    h.tag    = tag;
    return h;
  endfunction

  // Well-formed frame length for a rule; the authenticated rule may wrap here and so fail
  function automatic logic [7:0] frame_for(logic [1:0] op, logic [7:0] plen);
    case (op)
      prf_pkg::OP_CTR:  return 8'(prf_pkg::HDR_SHORT + plen);
      prf_pkg::OP_SESS: return 8'(prf_pkg::HDR_LONG + plen);
      prf_pkg::OP_AUTH: return 8'(prf_pkg::HDR_LONG + prf_pkg::TAG_BYTES + plen);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic verdict_t screen_header(header_t h);
    verdict_t         v;
    prf_pkg::status_t st;
    int               r;
    logic             hit;
    r  = int'(h.opcode);
    st = prf_pkg::ST_OK;
    if (h.node >= NODES || h.opcode == OP_UNUSED) begin
      st = prf_pkg::ST_LEN;
    end else begin
      hit = seen_rules[r][h.node];
      case (h.opcode)
        prf_pkg::OP_CTR: begin
          if (8'(prf_pkg::HDR_SHORT + h.plen) != h.flen || h.plen > max_plen[r])
            st = prf_pkg::ST_LEN;
          else if (hit && h.ctr <= last_ctr[r][h.node])
            st = prf_pkg::ST_REPLAY;
        end
        prf_pkg::OP_SESS: begin
          if (8'(prf_pkg::HDR_LONG + h.plen) != h.flen || h.plen > max_plen[r])
            st = prf_pkg::ST_LEN;
          else if (hit && (h.sess < last_sess[r][h.node] ||
                   (h.sess == last_sess[r][h.node] && h.ctr <= last_ctr[r][h.node])))
            st = prf_pkg::ST_REPLAY;
        end
        default: begin
          // no wrap on the authenticated length; length, then tag, then replay
          if (int'(prf_pkg::HDR_LONG) + int'(prf_pkg::TAG_BYTES) + int'(h.plen) !=
              int'(h.flen) || h.plen > max_plen[r])
            st = prf_pkg::ST_LEN;
          else if (!h.tag)
            st = prf_pkg::ST_AUTH;
          else if (hit && h.sess == last_sess[r][h.node] && h.ctr <= last_ctr[r][h.node])
            st = prf_pkg::ST_REPLAY;
        end
      endcase
    end
    if (st == prf_pkg::ST_OK) begin
      seen_rules[r][h.node] = 1'b1;
      last_sess[r][h.node]  = h.sess;
      last_ctr[r][h.node]   = h.ctr;
    end
    v.accept = (st == prf_pkg::ST_OK);
    v.status = st;
    v.len    = (st == prf_pkg::ST_OK) ? h.plen : 8'd0;
    return v;
  endfunction

  // Random header, mostly well formed and aimed near the node's last session and counter
  function automatic header_t make_header(int node_span);
    header_t     h;
    logic [7:0]  lim;
    logic [31:0] ls;
    logic [31:0] lc;
    int          r;
    h.opcode = ($urandom_range(0, 39) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
    h.node   = 8'($urandom_range(0, node_span - 1));
    h.tag    = ($urandom_range(0, 7) != 0);
    lim = (h.opcode == OP_UNUSED) ? 8'hFF : max_plen[h.opcode];
    case ($urandom_range(0, 11))
      0:       h.plen = 8'($urandom);
      1:       h.plen = lim;
      2:       h.plen = 8'(lim + 1);
      default: h.plen = 8'($urandom_range(0, lim));
    endcase
    h.flen = ($urandom_range(0, 9) == 0) ? 8'($urandom) : frame_for(h.opcode, h.plen);
    r = (h.opcode == OP_UNUSED) ? 0 : int'(h.opcode);
    if (h.node < NODES && seen_rules[r][h.node]) begin
      ls = last_sess[r][h.node];
      lc = last_ctr[r][h.node];
    end else begin
      ls = $urandom;
      lc = $urandom;
    end
    case ($urandom_range(0, 9))
      0: begin
        h.sess = $urandom;
        h.ctr  = $urandom;
      end
      1: begin
        h.sess = ls;
        h.ctr  = lc;
      end
      2: begin
        h.sess = ls;
        h.ctr  = lc - $urandom_range(1, 8);
      end
      3: begin
        h.sess = ls - $urandom_range(1, 3);
        h.ctr  = lc + $urandom_range(1, 8);
      end
      4: begin
        h.sess = ls + $urandom_range(1, 3);
        h.ctr  = $urandom_range(0, 15);
      end
      5: begin
        h.sess = ls;
        h.ctr  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      default: begin
        h.sess = ls;
        h.ctr  = lc + $urandom_range(1, 8);
      end
    endcase
    return h;
  endfunction

  task automatic sender_gap();
    if (quiet) return;
    if (run_left > 0) begin
      run_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      run_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_header(header_t h);
    in_valid       <= 1'b1;
    in_opcode      <= h.opcode;
    in_node_id     <= h.node;
    in_session_id  <= h.sess;
    in_msg_counter <= h.ctr;
    in_payload_len <= h.plen;
    in_frame_len   <= h.flen;
    in_tag_ok      <= h.tag;
    do @(posedge clk); while (in_stall);
    verdict_q.push_back(screen_header(h));
    sender_gap();
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2);
    logic [1:0] regs [3];
    logic [7:0] vals [3];
    regs = '{prf_pkg::CFG_RULE0_MAX, prf_pkg::CFG_RULE1_MAX, prf_pkg::CFG_RULE2_MAX};
    vals = '{r0, r1, r2};
    settle_pipeline();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      max_plen[regs[i]] = vals[i];
    end
    // stray index: the block must drop it
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 8'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic probe_limits();
    logic [7:0] plen;
    for (int r = 0; r < 3; r++) begin
      for (int d = 0; d < 2; d++) begin
        plen = 8'(max_plen[r] + d);
        send_header(frame_hdr(2'(r), 8'(16 + r), $urandom, $urandom, plen,
                              frame_for(2'(r), plen), 1'b1));
      end
    end
  endtask

  task automatic test_rule_checks();
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd0, 32'h0, 32'h0, 8'd0, 8'd7, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd0, 32'hFFFF_FFFF, 32'h0, 8'd0, 8'd7, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd0, 32'h0, 32'hFFFF_FFFF, 8'd248, 8'd255,
                          1'b0));
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd0, 32'h0, 32'hFFFF_FFFF, 8'd248, 8'd255,
                          1'b0));
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd255, 32'h0, 32'h1, 8'd249, 8'd0, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd255, 32'h0, 32'h1, 8'd10, 8'd18, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd0, 32'h0, 32'h0, 8'd255, 8'd6, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd1, 32'd5, 32'd10, 8'd0, 8'd11, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd1, 32'd5, 32'd10, 8'd0, 8'd11, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd1, 32'd4, 32'd100, 8'd3, 8'd14, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd1, 32'd6, 32'd0, 8'd244, 8'd255, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd1, 32'd6, 32'd1, 8'd245, 8'd0, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 8'd12,
                          1'b0));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd2, 32'd7, 32'd50, 8'd0, 8'd27, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd2, 32'd7, 32'd50, 8'd0, 8'd27, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd2, 32'd7, 32'd49, 8'd0, 8'd27, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd2, 32'd3, 32'd1, 8'd228, 8'd255, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd2, 32'd3, 32'd2, 8'd229, 8'd0, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd2, 32'd3, 32'd2, 8'd4, 8'd20, 1'b1));
    send_header(frame_hdr(prf_pkg::OP_AUTH, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255,
                          8'd255, 1'b1));
    send_header(frame_hdr(OP_UNUSED, 8'd3, 32'h0, 32'h0, 8'd0, 8'd7, 1'b1));
    // tables are per rule: fresh rules on nodes already seen
    send_header(frame_hdr(prf_pkg::OP_CTR, 8'd1, 32'd9, 32'd9, 8'd0, 8'd7, 1'b0));
    send_header(frame_hdr(prf_pkg::OP_SESS, 8'd0, 32'h0, 32'h0, 8'd0, 8'd11, 1'b0));
  endtask

  task automatic test_length_limits();
    set_limits(8'd0, 8'd0, 8'd0);
    probe_limits();
    set_limits(prf_pkg::RULE0_MAX_RST, prf_pkg::RULE1_MAX_RST, prf_pkg::RULE2_MAX_RST);
    probe_limits();
    set_limits(8'($urandom_range(1, prf_pkg::RULE0_MAX_RST - 1)),
               8'($urandom_range(1, prf_pkg::RULE1_MAX_RST - 1)),
               8'($urandom_range(1, prf_pkg::RULE2_MAX_RST - 1)));
    probe_limits();
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    run_left = 48;
    repeat (40) send_header(make_header(4));
  endtask

  task automatic test_random_traffic(int count, int node_span, logic [7:0] r0, logic [7:0] r1,
                                     logic [7:0] r2);
    set_limits(r0, r1, r2);
    repeat (count) send_header(make_header(node_span));
  endtask

  task automatic test_steady_stream();
    quiet <= 1'b1;
    test_random_traffic(300, 8, 8'($urandom_range(0, prf_pkg::RULE0_MAX_RST)),
                        8'($urandom_range(0, prf_pkg::RULE1_MAX_RST)),
                        8'($urandom_range(0, prf_pkg::RULE2_MAX_RST)));
  endtask

  // Receiver: random stall bursts, one long hold per request, none once quiet
  initial begin : stall_gen
    int served;
    served = 0;
    forever begin
      if (hold_req != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet || $urandom_range(0, 1)) begin
        out_stall <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: accept %0d status %0d accepted_len %0d",
               out_accept, out_status, out_accepted_len);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_accept !== want.accept) begin
          $error("accept: expected %0d, got %0d", want.accept, out_accept);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_accepted_len !== want.len) begin
          $error("accepted_len: expected %0d, got %0d", want.len, out_accepted_len);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rule_checks();
    test_length_limits();
    test_backpressure();
    test_random_traffic(300, 4, prf_pkg::RULE0_MAX_RST, prf_pkg::RULE1_MAX_RST,
                        prf_pkg::RULE2_MAX_RST);
    test_random_traffic(300, NODES, 8'($urandom_range(0, prf_pkg::RULE0_MAX_RST)),
                        8'($urandom_range(0, prf_pkg::RULE1_MAX_RST)),
                        8'($urandom_range(0, prf_pkg::RULE2_MAX_RST)));
    test_random_traffic(300, 16, prf_pkg::RULE0_MAX_RST, prf_pkg::RULE1_MAX_RST,
                        prf_pkg::RULE2_MAX_RST);
    test_random_traffic(250, 2, 8'($urandom_range(0, prf_pkg::RULE0_MAX_RST)),
                        8'($urandom_range(0, prf_pkg::RULE1_MAX_RST)),
                        8'($urandom_range(0, prf_pkg::RULE2_MAX_RST)));
    test_steady_stream();
    in_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && verdict_q.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
design/prf_pkg.sv
design/prf_front.sv
design/prf_queue.sv
design/prf_back.sv
design/per_node_replay_filter.sv
tb/sv/tb.sv
